>>> rtl/core/dsic_pkg.sv
// Shared types and constants of the dead-band step controller with integral trigger.
// Holds opcodes, step directions, register indexes and fixed datapath widths.
// No dependencies.
package dsic_pkg;

  localparam int INTEG_WIDTH    = 48;
  localparam int TRIG_WIDTH     = 47;
  localparam int DB_WIDTH       = 15;
  localparam int APB_ADDR_WIDTH = 6;
  localparam int APB_DATA_WIDTH = 64;
  localparam int REG_IDX_LSB    = 3;
  localparam int REG_IDX_WIDTH  = 3;
  localparam int OPCODE_WIDTH   = 2;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_TICK       = 2'd0,
    OP_ACTIVATE   = 2'd1,
    OP_DEACTIVATE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_DEADBAND    = 3'd0,
    REG_UP_STEP     = 3'd1,
    REG_DOWN_STEP   = 3'd2,
    REG_UP_PERIOD   = 3'd3,
    REG_DOWN_PERIOD = 3'd4,
    REG_MAX_LEVEL   = 3'd5,
    REG_MIN_LEVEL   = 3'd6,
    REG_TRIGGER     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic updated;
    dir_e dir;
  } upd_flags_t;

endpackage

>>> rtl/core/dsic_regs.sv
// Configuration register file with an APB-style port.
// Depends on dsic_pkg for register indexes and port widths.
module dsic_regs #(
  parameter int LEVEL_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dsic_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [dsic_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [dsic_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                 pready,
  output logic [dsic_pkg::DB_WIDTH-1:0]        deadband_o,
  output logic [LEVEL_WIDTH-1:0]               up_step_o,
  output logic [LEVEL_WIDTH-1:0]               down_step_o,
  output logic [PERIOD_WIDTH-1:0]              up_period_o,
  output logic [PERIOD_WIDTH-1:0]              down_period_o,
  output logic [LEVEL_WIDTH-1:0]               max_level_o,
  output logic [LEVEL_WIDTH-1:0]               min_level_o,
  output logic [dsic_pkg::TRIG_WIDTH-1:0]      integral_trigger_o
);

  logic [dsic_pkg::DB_WIDTH-1:0]   deadband_q;
  logic [LEVEL_WIDTH-1:0]          up_step_q;
  logic [LEVEL_WIDTH-1:0]          down_step_q;
  logic [PERIOD_WIDTH-1:0]         up_period_q;
  logic [PERIOD_WIDTH-1:0]         down_period_q;
  logic [LEVEL_WIDTH-1:0]          max_level_q;
  logic [LEVEL_WIDTH-1:0]          min_level_q;
  logic [dsic_pkg::TRIG_WIDTH-1:0] trigger_q;
  logic                            wr_en;
  dsic_pkg::reg_idx_e              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = dsic_pkg::reg_idx_e'(
      paddr[dsic_pkg::REG_IDX_LSB +: dsic_pkg::REG_IDX_WIDTH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q    <= '0;
      up_step_q     <= '0;
      down_step_q   <= '0;
      up_period_q   <= PERIOD_WIDTH'(1);
      down_period_q <= PERIOD_WIDTH'(1);
      max_level_q   <= {1'b0, {(LEVEL_WIDTH-1){1'b1}}};
      min_level_q   <= {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
      trigger_q     <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        dsic_pkg::REG_DEADBAND:    deadband_q    <= pwdata[dsic_pkg::DB_WIDTH-1:0];
        dsic_pkg::REG_UP_STEP:     up_step_q     <= pwdata[LEVEL_WIDTH-1:0];
        dsic_pkg::REG_DOWN_STEP:   down_step_q   <= pwdata[LEVEL_WIDTH-1:0];
        dsic_pkg::REG_UP_PERIOD:   up_period_q   <= pwdata[PERIOD_WIDTH-1:0];
        dsic_pkg::REG_DOWN_PERIOD: down_period_q <= pwdata[PERIOD_WIDTH-1:0];
        dsic_pkg::REG_MAX_LEVEL:   max_level_q   <= pwdata[LEVEL_WIDTH-1:0];
        dsic_pkg::REG_MIN_LEVEL:   min_level_q   <= pwdata[LEVEL_WIDTH-1:0];
        dsic_pkg::REG_TRIGGER:     trigger_q     <= pwdata[dsic_pkg::TRIG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsic_pkg::REG_DEADBAND:    prdata = dsic_pkg::APB_DATA_WIDTH'(deadband_q);
      dsic_pkg::REG_UP_STEP:     prdata = dsic_pkg::APB_DATA_WIDTH'(up_step_q);
      dsic_pkg::REG_DOWN_STEP:   prdata = dsic_pkg::APB_DATA_WIDTH'(down_step_q);
      dsic_pkg::REG_UP_PERIOD:   prdata = dsic_pkg::APB_DATA_WIDTH'(up_period_q);
      dsic_pkg::REG_DOWN_PERIOD: prdata = dsic_pkg::APB_DATA_WIDTH'(down_period_q);
      dsic_pkg::REG_MAX_LEVEL:   prdata = dsic_pkg::APB_DATA_WIDTH'(max_level_q);
      dsic_pkg::REG_MIN_LEVEL:   prdata = dsic_pkg::APB_DATA_WIDTH'(min_level_q);
      dsic_pkg::REG_TRIGGER:     prdata = dsic_pkg::APB_DATA_WIDTH'(trigger_q);
      default:                   prdata = '0;
    endcase
  end

  assign deadband_o         = deadband_q;
  assign up_step_o          = up_step_q;
  assign down_step_o        = down_step_q;
  assign up_period_o        = up_period_q;
  assign down_period_o      = down_period_q;
  assign max_level_o        = max_level_q;
  assign min_level_o        = min_level_q;
  assign integral_trigger_o = trigger_q;

endmodule

>>> rtl/core/dsic_update.sv
// Next-state logic of the controller for one item: countdown, integrator, step and clamp.
// Depends on dsic_pkg for opcodes, directions and fixed widths.
module dsic_update #(
  parameter int LEVEL_WIDTH  = 24,
  parameter int SAMPLE_WIDTH = 16,
  parameter int PERIOD_WIDTH = 16
) (
  input  dsic_pkg::opcode_e                        opcode_i,
  input  logic signed [SAMPLE_WIDTH-1:0]           freq_deviation_i,
  input  logic signed [LEVEL_WIDTH-1:0]            level_i,
  input  logic signed [dsic_pkg::INTEG_WIDTH-1:0]  integ_i,
  input  logic [PERIOD_WIDTH-1:0]                  ticks_i,
  input  logic                                     down_sel_i,
  input  logic                                     active_i,
  input  logic [dsic_pkg::DB_WIDTH-1:0]            deadband_i,
  input  logic signed [LEVEL_WIDTH-1:0]            up_step_i,
  input  logic signed [LEVEL_WIDTH-1:0]            down_step_i,
  input  logic [PERIOD_WIDTH-1:0]                  up_period_i,
  input  logic [PERIOD_WIDTH-1:0]                  down_period_i,
  input  logic signed [LEVEL_WIDTH-1:0]            max_level_i,
  input  logic signed [LEVEL_WIDTH-1:0]            min_level_i,
  input  logic [dsic_pkg::TRIG_WIDTH-1:0]          integral_trigger_i,
  output logic signed [LEVEL_WIDTH-1:0]            level_o,
  output logic signed [dsic_pkg::INTEG_WIDTH-1:0]  integ_o,
  output logic [PERIOD_WIDTH-1:0]                  ticks_o,
  output logic                                     down_sel_o,
  output logic                                     active_o,
  output dsic_pkg::upd_flags_t                     flags_o
);

  localparam int IW  = dsic_pkg::INTEG_WIDTH;
  localparam int PW  = SAMPLE_WIDTH + PERIOD_WIDTH + 1;
  localparam int XW  = ((PW > IW) ? PW : IW) + 1;
  localparam int SUW = IW + 1;
  localparam int CW  = ((SAMPLE_WIDTH > dsic_pkg::DB_WIDTH + 1) ?
                        SAMPLE_WIDTH : (dsic_pkg::DB_WIDTH + 1)) + 1;
  localparam int LW1 = LEVEL_WIDTH + 1;

  localparam logic signed [XW-1:0]  PMAX = XW'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [XW-1:0]  PMIN = ~PMAX;
  localparam logic signed [SUW-1:0] SMAX = SUW'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [SUW-1:0] SMIN = ~SMAX;

  logic [PERIOD_WIDTH-1:0]  per_cur;
  logic [PERIOD_WIDTH-1:0]  per_eff;
  logic [PERIOD_WIDTH-1:0]  up_eff;
  logic [PERIOD_WIDTH-1:0]  down_eff;
  logic signed [PW-1:0]     prod;
  logic signed [XW-1:0]     prod_x;
  logic signed [IW-1:0]     prod_sat;
  logic signed [SUW-1:0]    sum;
  logic signed [IW-1:0]     integ_upd;
  logic signed [SUW-1:0]    integ_c;
  logic signed [SUW-1:0]    trig_c;
  logic signed [CW-1:0]     dev_c;
  logic signed [CW-1:0]     db_c;
  dsic_pkg::dir_e           upd_dir;
  logic                     upd_sel;
  logic signed [LEVEL_WIDTH-1:0] step;
  logic signed [LW1-1:0]    lsum;
  logic signed [LW1-1:0]    lo_c;
  logic signed [LW1-1:0]    hi_c;
  logic signed [LEVEL_WIDTH-1:0] upd_level;

  assign up_eff   = (up_period_i == '0) ? PERIOD_WIDTH'(1) : up_period_i;
  assign down_eff = (down_period_i == '0) ? PERIOD_WIDTH'(1) : down_period_i;
  assign per_cur  = down_sel_i ? down_period_i : up_period_i;
  assign per_eff  = (per_cur == '0) ? PERIOD_WIDTH'(1) : per_cur;

  assign prod     = PW'(freq_deviation_i) * $signed({1'b0, per_eff});
  assign prod_x   = XW'(prod);
  assign prod_sat = (prod_x > PMAX) ? IW'(PMAX) :
                    (prod_x < PMIN) ? IW'(PMIN) : IW'(prod_x);
  assign sum      = SUW'(integ_i) + SUW'(prod_sat);
  assign integ_upd = (sum > SMAX) ? IW'(SMAX) :
                     (sum < SMIN) ? IW'(SMIN) : IW'(sum);

  assign integ_c = SUW'(integ_upd);
  assign trig_c  = $signed(SUW'(integral_trigger_i));
  assign dev_c   = CW'(freq_deviation_i);
  assign db_c    = $signed(CW'(deadband_i));

  always_comb begin
    upd_sel = 1'b0;
    upd_dir = dsic_pkg::DIR_NONE;
    if (dev_c > db_c) begin
      upd_dir = dsic_pkg::DIR_UP;
    end else if (dev_c < -db_c) begin
      upd_dir = dsic_pkg::DIR_DOWN;
      upd_sel = 1'b1;
    end else if (integ_c > trig_c) begin
      upd_dir = dsic_pkg::DIR_UP;
    end else if (integ_c < -trig_c) begin
      upd_dir = dsic_pkg::DIR_DOWN;
    end
  end

  assign step = (upd_dir == dsic_pkg::DIR_UP)   ? up_step_i :
                (upd_dir == dsic_pkg::DIR_DOWN) ? down_step_i : '0;
  assign lsum = LW1'(level_i) + LW1'(step);
  assign lo_c = LW1'(min_level_i);
  assign hi_c = LW1'(max_level_i);
  assign upd_level = (lsum < lo_c) ? min_level_i :
                     (lsum > hi_c) ? max_level_i : LEVEL_WIDTH'(lsum);

  always_comb begin
    level_o          = level_i;
    integ_o          = integ_i;
    ticks_o          = ticks_i;
    down_sel_o       = down_sel_i;
    active_o         = active_i;
    flags_o.updated  = 1'b0;
    flags_o.dir      = dsic_pkg::DIR_NONE;
    case (opcode_i)
      dsic_pkg::OP_TICK: begin
        if (active_i) begin
          if (ticks_i > PERIOD_WIDTH'(1)) begin
            ticks_o = ticks_i - PERIOD_WIDTH'(1);
          end else begin
            level_o         = upd_level;
            integ_o         = integ_upd;
            down_sel_o      = upd_sel;
            ticks_o         = upd_sel ? down_eff : up_eff;
            flags_o.updated = 1'b1;
            flags_o.dir     = upd_dir;
          end
        end
      end
      dsic_pkg::OP_ACTIVATE: begin
        active_o = 1'b1;
        ticks_o  = up_eff;
      end
      dsic_pkg::OP_DEACTIVATE: begin
        level_o  = '0;
        active_o = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/deadband_step_integral_controller.sv
// Top level of the dead-band step controller with integral trigger.
// Depends on dsic_pkg, dsic_regs and dsic_update.
//
// Usage: items enter on the s_axis channel. tuser carries the opcode (tick,
// activate, deactivate) and tdata the signed frequency deviation used on ticks.
// Every item gives exactly one result on the m_axis channel with the level,
// the updated flag, the step direction, the period in use and the active flag.
// Registers are to be written through the APB-style port only while the stream
// is idle; the block itself does not enforce this. An item is held in an input
// register, its next state and result are formed in one combinational pass,
// and the result lands in the output register. The block takes one item per
// cycle while the receiver accepts results; the integrator multiply-add and
// the level clamp lie between the input register and the output register.
// When the receiver stalls, the output register holds its result and the
// input register fills; s_axis_tready then drops until the result is taken.
// Reset clears the state (level, integrator, countdown, period selection,
// active flag) and restores the register defaults; no result is pending.
module deadband_step_integral_controller #(
  parameter int LEVEL_WIDTH  = 24,
  parameter int SAMPLE_WIDTH = 16,
  parameter int PERIOD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // freq_deviation
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // opcode
  input  logic [dsic_pkg::OPCODE_WIDTH-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // level, updated, direction, period_select, is_active
  output logic [((LEVEL_WIDTH+12)/8)*8-1:0]   m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dsic_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [dsic_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [dsic_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);

  localparam int IW     = dsic_pkg::INTEG_WIDTH;
  localparam int OUT_TW = ((LEVEL_WIDTH + 12) / 8) * 8;

  logic [dsic_pkg::DB_WIDTH-1:0]   cfg_deadband;
  logic [LEVEL_WIDTH-1:0]          cfg_up_step;
  logic [LEVEL_WIDTH-1:0]          cfg_down_step;
  logic [PERIOD_WIDTH-1:0]         cfg_up_period;
  logic [PERIOD_WIDTH-1:0]         cfg_down_period;
  logic [LEVEL_WIDTH-1:0]          cfg_max_level;
  logic [LEVEL_WIDTH-1:0]          cfg_min_level;
  logic [dsic_pkg::TRIG_WIDTH-1:0] cfg_trigger;

  logic                            in_valid_q;
  dsic_pkg::opcode_e               in_opcode_q;
  logic signed [SAMPLE_WIDTH-1:0]  in_dev_q;
  logic                            advance;

  logic signed [LEVEL_WIDTH-1:0]   level_q, level_d;
  logic signed [IW-1:0]            integ_q, integ_d;
  logic [PERIOD_WIDTH-1:0]         ticks_q, ticks_d;
  logic                            down_sel_q, down_sel_d;
  logic                            active_q, active_d;
  dsic_pkg::upd_flags_t            flags_d;

  logic                            out_valid_q;
  logic signed [LEVEL_WIDTH-1:0]   out_level_q;
  dsic_pkg::upd_flags_t            out_flags_q;
  logic                            out_sel_q;
  logic                            out_active_q;

  dsic_regs #(
    .LEVEL_WIDTH  (LEVEL_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .deadband_o         (cfg_deadband),
    .up_step_o          (cfg_up_step),
    .down_step_o        (cfg_down_step),
    .up_period_o        (cfg_up_period),
    .down_period_o      (cfg_down_period),
    .max_level_o        (cfg_max_level),
    .min_level_o        (cfg_min_level),
    .integral_trigger_o (cfg_trigger)
  );

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_opcode_q <= dsic_pkg::opcode_e'(s_axis_tuser);
      in_dev_q    <= s_axis_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  dsic_update #(
    .LEVEL_WIDTH  (LEVEL_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_update (
    .opcode_i           (in_opcode_q),
    .freq_deviation_i   (in_dev_q),
    .level_i            (level_q),
    .integ_i            (integ_q),
    .ticks_i            (ticks_q),
    .down_sel_i         (down_sel_q),
    .active_i           (active_q),
    .deadband_i         (cfg_deadband),
    .up_step_i          (cfg_up_step),
    .down_step_i        (cfg_down_step),
    .up_period_i        (cfg_up_period),
    .down_period_i      (cfg_down_period),
    .max_level_i        (cfg_max_level),
    .min_level_i        (cfg_min_level),
    .integral_trigger_i (cfg_trigger),
    .level_o            (level_d),
    .integ_o            (integ_d),
    .ticks_o            (ticks_d),
    .down_sel_o         (down_sel_d),
    .active_o           (active_d),
    .flags_o            (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      integ_q     <= '0;
      ticks_q     <= '0;
      down_sel_q  <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        level_q    <= level_d;
        integ_q    <= integ_d;
        ticks_q    <= ticks_d;
        down_sel_q <= down_sel_d;
        active_q   <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_level_q  <= level_d;
      out_flags_q  <= flags_d;
      out_sel_q    <= down_sel_d;
      out_active_q <= active_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_active_q, out_sel_q, out_flags_q.dir,
                                  out_flags_q.updated, out_level_q});

`ifndef SYNTHESIS
  a_active_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (ticks_q != '0))
    else $error("countdown is zero while active");

  a_update_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_flags_q.updated) |-> out_active_q)
    else $error("update reported while inactive");

  a_step_needs_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_flags_q.dir != dsic_pkg::DIR_NONE)) |-> out_flags_q.updated)
    else $error("step reported without an update");

  a_state_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(level_q) && $stable(integ_q) && $stable(ticks_q)))
    else $error("state changed while the output was stalled");
`endif

endmodule
